// ===== rtl/core/tbvs_pkg.sv =====
package tbvs_pkg;

	localparam int PALETTE_SLOTS = 64;
	localparam int FRAC_BITS = 16;
	localparam int SLOT_W = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1;
	localparam int MAT_ELEMS = 12;
	localparam int ELEM_W = 4;
	localparam int WGT_BITS = 16;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;
	localparam logic [16:0] SNAP_HIGH = 17'd64225;
	localparam logic [16:0] SNAP_LOW = 17'd1311;
	localparam int NRM_FRAC = 14;
	localparam int ACC_W = 50;
	localparam int MAG_W = 30;
	localparam int LEN2_W = 2 * MAG_W + 2;
	localparam int LEN_W = LEN2_W / 2;
	localparam int SQRT_STEPS = LEN_W;
	localparam int DIV_STEPS = NRM_FRAC + 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_SKIN = 1'b1
	} op_t;

	typedef struct packed {
		logic [MAT_ELEMS-1:0][31:0] ea;
		logic [MAT_ELEMS-1:0][31:0] eb;
		logic [16:0]                w;
		logic [2:0][31:0]           pos;
		logic [2:0][15:0]           nrm;
	} item_t;

endpackage

// ===== rtl/core/tbvs_front.sv =====
module tbvs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [6:0]           cfg_wdata,
	input  logic                 push,
	output logic                 full,
	input  logic                 opcode,
	input  logic [7:0]           bone_a,
	input  logic [7:0]           bone_b,
	input  logic [16:0]          weight,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic signed [15:0]   nrm_x,
	input  logic signed [15:0]   nrm_y,
	input  logic signed [15:0]   nrm_z,
	output tbvs_pkg::item_t      q_item,
	output logic                 q_push,
	input  logic                 q_full
);
	import tbvs_pkg::*;

	logic [7:0]  bc_max_q;
	logic [8:0]  cfg_ext;
	logic        acc;
	logic        wr_en;
	logic        rd_en;
	logic [7:0]  ba_c;
	logic [7:0]  bb_c;
	logic [7:0]  ba_f;
	logic [16:0] w_c;

	logic        vld_s1;
	logic [31:0] ea_s1 [MAT_ELEMS];
	logic [31:0] eb_s1 [MAT_ELEMS];
	logic [16:0] w_s1;
	logic [2:0][31:0] pos_s1;
	logic [2:0][15:0] nrm_s1;

	assign cfg_ext = {2'b00, cfg_wdata};

	// keep bone_count-1 after clamping to 1..PALETTE_SLOTS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_max_q <= '0;
		end else if (cfg_we) begin
			if (cfg_ext == 9'd0) begin
				bc_max_q <= '0;
			end else if (cfg_ext > 9'(PALETTE_SLOTS)) begin
				bc_max_q <= 8'(PALETTE_SLOTS - 1);
			end else begin
				bc_max_q <= 8'(cfg_ext - 9'd1);
			end
		end
	end

	assign full   = vld_s1 && q_full;
	assign q_push = vld_s1 && !q_full;
	assign acc    = push && !full;

	assign wr_en = acc && (op_t'(opcode) == OP_LOAD) && ({1'b0, bone_a} < 9'(PALETTE_SLOTS))
		&& (bone_b < 8'(MAT_ELEMS));
	assign rd_en = acc && (op_t'(opcode) == OP_SKIN);

	always_comb begin
		ba_c = (bone_a > bc_max_q) ? bc_max_q : bone_a;
		bb_c = (bone_b > bc_max_q) ? bc_max_q : bone_b;
		w_c  = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
		if (ba_c == bb_c || w_c > SNAP_HIGH) begin
			w_c = WEIGHT_ONE;
		end
		ba_f = ba_c;
		// tiny weight: all of it goes to the second bone
		if (w_c < SNAP_LOW) begin
			w_c  = '0;
			ba_f = bb_c;
		end
	end

	// one bank per matrix element, read at both bones
	for (genvar k = 0; k < MAT_ELEMS; k++) begin : g_bank
		logic [31:0] mem [PALETTE_SLOTS];
		always_ff @(posedge clk) begin
			if (wr_en && bone_b[ELEM_W-1:0] == ELEM_W'(k)) begin
				mem[bone_a[SLOT_W-1:0]] <= pos_x;
			end
			if (rd_en) begin
				ea_s1[k] <= mem[ba_f[SLOT_W-1:0]];
				eb_s1[k] <= mem[bb_c[SLOT_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rd_en) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			w_s1   <= w_c;
			pos_s1 <= {pos_z, pos_y, pos_x};
			nrm_s1 <= {nrm_z, nrm_y, nrm_x};
		end
	end

	always_comb begin
		for (int k = 0; k < MAT_ELEMS; k++) begin
			q_item.ea[k] = ea_s1[k];
			q_item.eb[k] = eb_s1[k];
		end
		q_item.w   = w_s1;
		q_item.pos = pos_s1;
		q_item.nrm = nrm_s1;
	end

endmodule

// ===== rtl/core/tbvs_fifo.sv =====
module tbvs_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tbvs_pkg::item_t din,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output tbvs_pkg::item_t dout
);
	import tbvs_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

// ===== rtl/core/tbvs_isqrt.sv =====
module tbvs_isqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tbvs_pkg::LEN2_W-1:0] x,
	output logic [tbvs_pkg::LEN_W-1:0]  root
);
	import tbvs_pkg::*;

	localparam int REM_W = LEN_W + 2;

	logic [REM_W-1:0]  rem_q  [SQRT_STEPS];
	logic [LEN_W-1:0]  root_q [SQRT_STEPS];
	logic [LEN2_W-1:0] x_q    [SQRT_STEPS];

	// one root bit per stage, two radicand bits consumed per stage
	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		logic [REM_W-1:0]  rem_in;
		logic [LEN_W-1:0]  root_in;
		logic [LEN2_W-1:0] x_in;
		logic [REM_W+1:0]  t;
		logic [REM_W+1:0]  trial;

		if (i == 0) begin : g_first
			always_comb begin
				rem_in  = '0;
				root_in = '0;
				x_in    = x;
			end
		end else begin : g_next
			always_comb begin
				rem_in  = rem_q[i-1];
				root_in = root_q[i-1];
				x_in    = x_q[i-1];
			end
		end

		always_comb begin
			t     = {rem_in, x_in[LEN2_W-1 -: 2]};
			trial = {2'b00, root_in, 2'b01};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= trial) begin
					rem_q[i]  <= REM_W'(t - trial);
					root_q[i] <= {root_in[LEN_W-2:0], 1'b1};
				end else begin
					rem_q[i]  <= t[REM_W-1:0];
					root_q[i] <= {root_in[LEN_W-2:0], 1'b0};
				end
				x_q[i] <= {x_in[LEN2_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_q[SQRT_STEPS-1];

endmodule

// ===== rtl/core/tbvs_div.sv =====
module tbvs_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [tbvs_pkg::LEN_W-1:0]   len,
	input  logic [tbvs_pkg::MAG_W-1:0]   mag,
	output logic [tbvs_pkg::DIV_STEPS-1:0] q
);
	import tbvs_pkg::*;

	localparam int NUM_W = MAG_W + NRM_FRAC + 1;

	logic [NUM_W-1:0]     num;
	logic [LEN_W-1:0]     rem_q [DIV_STEPS];
	logic [DIV_STEPS-1:0] lo_q  [DIV_STEPS];
	logic [DIV_STEPS-1:0] q_q   [DIV_STEPS];
	logic [LEN_W-1:0]     len_q [DIV_STEPS];

	// rounded numerator; mag <= len keeps the quotient inside DIV_STEPS bits
	assign num = NUM_W'({mag, {NRM_FRAC{1'b0}}}) + NUM_W'(len >> 1);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [LEN_W-1:0]     rem_in;
		logic [DIV_STEPS-1:0] lo_in;
		logic [DIV_STEPS-1:0] q_in;
		logic [LEN_W-1:0]     len_in;
		logic [LEN_W:0]       t;

		if (i == 0) begin : g_first
			always_comb begin
				rem_in = LEN_W'(num[NUM_W-1:DIV_STEPS]);
				lo_in  = num[DIV_STEPS-1:0];
				q_in   = '0;
				len_in = len;
			end
		end else begin : g_next
			always_comb begin
				rem_in = rem_q[i-1];
				lo_in  = lo_q[i-1];
				q_in   = q_q[i-1];
				len_in = len_q[i-1];
			end
		end

		assign t = {rem_in, lo_in[DIV_STEPS-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {1'b0, len_in}) begin
					rem_q[i] <= LEN_W'(t - {1'b0, len_in});
					q_q[i]   <= {q_in[DIV_STEPS-2:0], 1'b1};
				end else begin
					rem_q[i] <= t[LEN_W-1:0];
					q_q[i]   <= {q_in[DIV_STEPS-2:0], 1'b0};
				end
				lo_q[i]  <= {lo_in[DIV_STEPS-2:0], 1'b0};
				len_q[i] <= len_in;
			end
		end
	end

	assign q = q_q[DIV_STEPS-1];

endmodule

// ===== rtl/core/tbvs_back.sv =====
module tbvs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tbvs_pkg::item_t  q_item,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [2:0][31:0] out_pos,
	output logic [2:0][15:0] out_nrm
);
	import tbvs_pkg::*;

	localparam int SH_W = $clog2(ACC_W - MAG_W + 1);
	localparam int PIPE_STAGES = 10 + SQRT_STEPS + DIV_STEPS;
	localparam logic signed [65:0] POS_HALF = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [50:0] WGT_HALF = 51'sd1 <<< (WGT_BITS - 1);
	localparam logic signed [66:0] S32_MAX = 67'sd2147483647;
	localparam logic signed [66:0] S32_MIN = -67'sd2147483648;

	typedef struct packed {
		logic [2:0][31:0]      opos;
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mags;
	} side_t;

	typedef struct packed {
		logic [2:0][31:0] opos;
		logic [2:0]       neg;
		logic             zero;
	} dside_t;

	logic                   adv;
	logic                   load_out;
	logic                   v_last;
	logic [PIPE_STAGES-1:0] vld_q;

	logic signed [32:0] d_s1   [MAT_ELEMS];
	logic signed [31:0] eb_s1  [MAT_ELEMS];
	logic [16:0]        w_s1;
	logic signed [31:0] pos_s1 [3];
	logic signed [15:0] nrm_s1 [3];

	logic signed [50:0] prod_c [MAT_ELEMS];
	logic signed [50:0] pr_s2  [MAT_ELEMS];
	logic signed [31:0] eb_s2  [MAT_ELEMS];
	logic signed [31:0] pos_s2 [3];
	logic signed [15:0] nrm_s2 [3];

	logic signed [50:0] msum_c [MAT_ELEMS];
	logic signed [31:0] m_s3   [MAT_ELEMS];
	logic signed [31:0] pos_s3 [3];
	logic signed [15:0] nrm_s3 [3];

	logic signed [63:0] pp_s4  [3][3];
	logic signed [47:0] np_s4  [3][3];
	logic signed [31:0] t_s4   [3];

	logic signed [65:0] ps_s5  [3];
	logic signed [49:0] acc_s5 [3];
	logic signed [31:0] t_s5   [3];

	logic signed [66:0] hs_c   [3];
	logic [2:0][31:0]   opos_s6;
	logic [ACC_W-1:0]   mag_s6 [3];
	logic [2:0]         neg_s6;

	logic [ACC_W-1:0]   orv_c;
	logic [SH_W-1:0]    sh_c;
	logic [SH_W-1:0]    sh_s7;
	logic [ACC_W-1:0]   mag_s7 [3];
	logic [2:0][31:0]   opos_s7;
	logic [2:0]         neg_s7;

	logic [2:0][MAG_W-1:0] mags_s8;
	logic [2:0][31:0]      opos_s8;
	logic [2:0]            neg_s8;

	logic [2*MAG_W-1:0]    sq_s9 [3];
	logic [2:0][MAG_W-1:0] mags_s9;
	logic [2:0][31:0]      opos_s9;
	logic [2:0]            neg_s9;

	logic [LEN2_W-1:0]     len2_s10;
	side_t                 side_s10;

	side_t                 side_q  [SQRT_STEPS];
	dside_t                dside_q [DIV_STEPS];
	logic [LEN_W-1:0]      root;
	logic [DIV_STEPS-1:0]  quo [3];

	logic                  ovld_q;
	logic [2:0][31:0]      opos_q;
	logic [2:0][15:0]      onrm_q;
	logic [2:0][15:0]      onrm_c;

	// whole pipe moves together; it only waits when a result is held at the output
	assign v_last   = vld_q[PIPE_STAGES-1];
	assign load_out = !ovld_q || pop;
	assign adv      = load_out || !v_last;
	assign q_pop    = adv && !q_empty;
	assign empty    = !ovld_q;
	assign out_pos  = opos_q;
	assign out_nrm  = onrm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[PIPE_STAGES-2:0], !q_empty};
			end
			if (load_out) begin
				ovld_q <= v_last;
			end
		end
	end

	// s1: element differences, m = eb + (ea - eb) * w
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < MAT_ELEMS; k++) begin
				d_s1[k]  <= $signed({q_item.ea[k][31], q_item.ea[k]})
					- $signed({q_item.eb[k][31], q_item.eb[k]});
				eb_s1[k] <= $signed(q_item.eb[k]);
			end
			w_s1 <= q_item.w;
			for (int c = 0; c < 3; c++) begin
				pos_s1[c] <= $signed(q_item.pos[c]);
				nrm_s1[c] <= $signed(q_item.nrm[c]);
			end
		end
	end

	// s2: weight products
	always_comb begin
		for (int k = 0; k < MAT_ELEMS; k++) begin
			prod_c[k] = d_s1[k] * $signed({1'b0, w_s1});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s2  <= prod_c;
			eb_s2  <= eb_s1;
			pos_s2 <= pos_s1;
			nrm_s2 <= nrm_s1;
		end
	end

	// s3: blended matrix, round half up
	always_comb begin
		for (int k = 0; k < MAT_ELEMS; k++) begin
			msum_c[k] = ((pr_s2[k] + WGT_HALF) >>> WGT_BITS) + eb_s2[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < MAT_ELEMS; k++) begin
				m_s3[k] <= msum_c[k][31:0];
			end
			pos_s3 <= pos_s2;
			nrm_s3 <= nrm_s2;
		end
	end

	// s4: matrix times position and normal
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					pp_s4[r][c] <= m_s3[c*3+r] * pos_s3[c];
					np_s4[r][c] <= m_s3[c*3+r] * nrm_s3[c];
				end
				t_s4[r] <= m_s3[9+r];
			end
		end
	end

	// s5: row sums
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				ps_s5[r]  <= pp_s4[r][0] + pp_s4[r][1] + pp_s4[r][2] + POS_HALF;
				acc_s5[r] <= np_s4[r][0] + np_s4[r][1] + np_s4[r][2];
			end
			t_s5 <= t_s4;
		end
	end

	// s6: translate and saturate position, magnitudes of normal
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			hs_c[r] = (ps_s5[r] >>> FRAC_BITS) + t_s5[r];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				if (hs_c[r] > S32_MAX) begin
					opos_s6[r] <= 32'h7fff_ffff;
				end else if (hs_c[r] < S32_MIN) begin
					opos_s6[r] <= 32'h8000_0000;
				end else begin
					opos_s6[r] <= hs_c[r][31:0];
				end
				mag_s6[r] <= acc_s5[r][ACC_W-1] ? ACC_W'(-acc_s5[r]) : acc_s5[r];
				neg_s6[r] <= acc_s5[r][ACC_W-1];
			end
		end
	end

	// s7: how far to shift so the largest magnitude fits MAG_W bits
	always_comb begin
		orv_c = mag_s6[0] | mag_s6[1] | mag_s6[2];
		sh_c  = '0;
		for (int i = 0; i < ACC_W - MAG_W; i++) begin
			if (orv_c[MAG_W+i]) begin
				sh_c = SH_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sh_s7   <= sh_c;
			mag_s7  <= mag_s6;
			opos_s7 <= opos_s6;
			neg_s7  <= neg_s6;
		end
	end

	// s8: scaled magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				mags_s8[k] <= MAG_W'(mag_s7[k] >> sh_s7);
			end
			opos_s8 <= opos_s7;
			neg_s8  <= neg_s7;
		end
	end

	// s9: squares
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				sq_s9[k] <= mags_s8[k] * mags_s8[k];
			end
			mags_s9 <= mags_s8;
			opos_s9 <= opos_s8;
			neg_s9  <= neg_s8;
		end
	end

	// s10: squared length
	always_ff @(posedge clk) begin
		if (adv) begin
			len2_s10      <= LEN2_W'(sq_s9[0]) + LEN2_W'(sq_s9[1]) + LEN2_W'(sq_s9[2]);
			side_s10.opos <= opos_s9;
			side_s10.neg  <= neg_s9;
			side_s10.mags <= mags_s9;
		end
	end

	tbvs_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.x    (len2_s10),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_s10;
			for (int i = 1; i < SQRT_STEPS; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_div
		tbvs_div u_div (
			.clk (clk),
			.en  (adv),
			.len (root),
			.mag (side_q[SQRT_STEPS-1].mags[k]),
			.q   (quo[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dside_q[0].opos <= side_q[SQRT_STEPS-1].opos;
			dside_q[0].neg  <= side_q[SQRT_STEPS-1].neg;
			dside_q[0].zero <= (root == '0);
			for (int i = 1; i < DIV_STEPS; i++) begin
				dside_q[i] <= dside_q[i-1];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (dside_q[DIV_STEPS-1].zero) begin
				onrm_c[k] = '0;
			end else if (dside_q[DIV_STEPS-1].neg[k]) begin
				onrm_c[k] = ~16'(quo[k]) + 16'd1;
			end else begin
				onrm_c[k] = 16'(quo[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			opos_q <= dside_q[DIV_STEPS-1].opos;
			onrm_q <= onrm_c;
		end
	end

endmodule

// ===== rtl/core/two_bone_vertex_skinning_core.sv =====
// channel   direction  handshake            payload
// input     in         push / full          opcode bone_a bone_b weight pos_* nrm_*
// result    out        pop / empty          out_pos_* out_nrm_*
// config    in         cfg_we               cfg_wdata (bone_count)
//
// while full is low, one load or vertex accepted per cycle; loads give no result
// a vertex result goes through the front register, the queue, back stages s1..s10,
// square root (one bit per stage) and normal divide (one quotient bit per stage)
// arst_n clears control state and sets bone_count to 1; palette holds garbage until loaded
// a held result stalls the back pipe; the two-entry queue then fills and raises full
module two_bone_vertex_skinning_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_wdata,
	input  logic                push,
	output logic                full,
	input  logic                opcode,
	input  logic [7:0]          bone_a,
	input  logic [7:0]          bone_b,
	input  logic [16:0]         weight,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [15:0]  nrm_x,
	input  logic signed [15:0]  nrm_y,
	input  logic signed [15:0]  nrm_z,
	output logic                empty,
	input  logic                pop,
	output logic signed [31:0]  out_pos_x,
	output logic signed [31:0]  out_pos_y,
	output logic signed [31:0]  out_pos_z,
	output logic signed [15:0]  out_nrm_x,
	output logic signed [15:0]  out_nrm_y,
	output logic signed [15:0]  out_nrm_z
);
	import tbvs_pkg::*;

	item_t            f_item;
	item_t            b_item;
	logic             f_push;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	logic [2:0][31:0] out_pos;
	logic [2:0][15:0] out_nrm;

	tbvs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.bone_a    (bone_a),
		.bone_b    (bone_b),
		.weight    (weight),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.nrm_x     (nrm_x),
		.nrm_y     (nrm_y),
		.nrm_z     (nrm_z),
		.q_item    (f_item),
		.q_push    (f_push),
		.q_full    (q_full)
	);

	tbvs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (f_item),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.dout   (b_item)
	);

	tbvs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (b_item),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.out_pos (out_pos),
		.out_nrm (out_nrm)
	);

	assign out_pos_x = out_pos[0];
	assign out_pos_y = out_pos[1];
	assign out_pos_z = out_pos[2];
	assign out_nrm_x = out_nrm[0];
	assign out_nrm_y = out_nrm[1];
	assign out_nrm_z = out_nrm[2];

endmodule
